>>> design/twin_triangle_basis_eval_defines.svh
// Assertion macros used by the checker file of the basis evaluator
`ifndef TWIN_TRIANGLE_BASIS_EVAL_DEFINES_SVH
`define TWIN_TRIANGLE_BASIS_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define TTBE_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTBE_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ttbe_pkg.sv
// Shared widths, op codes and transaction types of the basis evaluator
package ttbe_pkg;

	localparam int CW   = 32;            // coordinate and result width
	localparam int FB   = 16;            // fraction bits
	localparam int DW   = CW + 1;        // coordinate difference
	localparam int PW   = 2 * DW;        // product of two differences
	localparam int AW   = PW + 1;        // doubled area
	localparam int NSW  = AW + FB + 2;   // signed dividend before rounding
	localparam int NUMW = AW + FB + 3;   // rounded dividend magnitude
	localparam int XW   = NUMW + CW;     // divider datapath width

	localparam logic [3:0] OP_VAL1  = 4'd0;
	localparam logic [3:0] OP_VAL2  = 4'd1;
	localparam logic [3:0] OP_VAL3  = 4'd2;
	localparam logic [3:0] OP_VAL4  = 4'd3;
	localparam logic [3:0] OP_VAL5  = 4'd4;
	localparam logic [3:0] OP_GRAD1 = 4'd5;
	localparam logic [3:0] OP_GRAD2 = 4'd6;
	localparam logic [3:0] OP_GRAD3 = 4'd7;
	localparam logic [3:0] OP_GRAD4 = 4'd8;
	localparam logic [3:0] OP_GRAD5 = 4'd9;

	typedef struct packed {
		logic [3:0]           op;
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] v0x;
		logic signed [CW-1:0] v0y;
		logic signed [CW-1:0] v1x;
		logic signed [CW-1:0] v1y;
		logic signed [CW-1:0] v2x;
		logic signed [CW-1:0] v2y;
		logic signed [CW-1:0] v3x;
		logic signed [CW-1:0] v3y;
	} item_t;

	typedef struct packed {
		logic signed [CW-1:0] first_value;
		logic signed [CW-1:0] second_value;
		logic                 zero_area;
	} res_t;

	// geometry front end to divider
	typedef struct packed {
		logic signed [NSW-1:0] n1;
		logic signed [NSW-1:0] n2;
		logic signed [AW-1:0]  own;
		logic                  kill;
		logic                  zero;
	} geo_t;

endpackage

>>> design/ttbe_geom.sv
// Geometry front end: differences, products, areas, triangle choice, dividends
module ttbe_geom import ttbe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  item_t item,
	output logic  out_valid,
	output geo_t  geo
);

	logic signed [CW-1:0] vx [4];
	logic signed [CW-1:0] vy [4];
	logic [1:0] ib, ic;

	assign vx[0] = item.v0x; assign vy[0] = item.v0y;
	assign vx[1] = item.v1x; assign vy[1] = item.v1y;
	assign vx[2] = item.v2x; assign vy[2] = item.v2y;
	assign vx[3] = item.v3x; assign vy[3] = item.v3y;

	// edge (b,c) of the op; the fifth function uses v2,v0
	always_comb begin
		unique case (item.op) inside
			OP_VAL1, OP_GRAD1: begin ib = 2'd0; ic = 2'd1; end
			OP_VAL2, OP_GRAD2: begin ib = 2'd1; ic = 2'd2; end
			OP_VAL3, OP_GRAD3: begin ib = 2'd2; ic = 2'd3; end
			OP_VAL4, OP_GRAD4: begin ib = 2'd3; ic = 2'd0; end
			default:           begin ib = 2'd2; ic = 2'd0; end
		endcase
	end

	function automatic logic signed [DW-1:0] dif(logic signed [CW-1:0] b,
		logic signed [CW-1:0] a);
		return DW'(b) - DW'(a);
	endfunction

	// stage 1: the four differences of each cross product
	logic                 vld_s1;
	logic [3:0]           op_s1;
	logic signed [DW-1:0] lo_s1 [4];
	logic signed [DW-1:0] lt_s1 [4];
	logic signed [DW-1:0] ro_s1 [4];
	logic signed [DW-1:0] rt_s1 [4];
	logic signed [DW-1:0] gx_s1, gy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= item.op;
			// T1 = (v0,v1,v2)
			lo_s1[0] <= dif(vx[1], vx[0]); lt_s1[0] <= dif(vy[2], vy[0]);
			ro_s1[0] <= dif(vy[1], vy[0]); rt_s1[0] <= dif(vx[2], vx[0]);
			// T2 = (v0,v2,v3)
			lo_s1[1] <= dif(vx[2], vx[0]); lt_s1[1] <= dif(vy[3], vy[0]);
			ro_s1[1] <= dif(vy[2], vy[0]); rt_s1[1] <= dif(vx[3], vx[0]);
			// side of diagonal, (v0,p,v2)
			lo_s1[2] <= dif(item.px, vx[0]); lt_s1[2] <= dif(vy[2], vy[0]);
			ro_s1[2] <= dif(item.py, vy[0]); rt_s1[2] <= dif(vx[2], vx[0]);
			// sub-area (p,b,c)
			lo_s1[3] <= dif(vx[ib], item.px); lt_s1[3] <= dif(vy[ic], item.py);
			ro_s1[3] <= dif(vy[ib], item.py); rt_s1[3] <= dif(vx[ic], item.px);
			gx_s1    <= dif(vy[ib], vy[ic]);
			gy_s1    <= dif(vx[ic], vx[ib]);
		end
	end

	// stage 2: products
	logic                 vld_s2;
	logic [3:0]           op_s2;
	logic signed [PW-1:0] pl_s2 [4];
	logic signed [PW-1:0] pr_s2 [4];
	logic signed [DW-1:0] gx_s2, gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			gx_s2 <= gx_s1;
			gy_s2 <= gy_s1;
			for (int i = 0; i < 4; i++) begin
				pl_s2[i] <= PW'(lo_s1[i]) * PW'(lt_s1[i]);
				pr_s2[i] <= PW'(ro_s1[i]) * PW'(rt_s1[i]);
			end
		end
	end

	// stage 3: doubled areas
	logic                 vld_s3;
	logic [3:0]           op_s3;
	logic signed [AW-1:0] ar_s3 [4];
	logic signed [DW-1:0] gx_s3, gy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3 <= op_s2;
			gx_s3 <= gx_s2;
			gy_s3 <= gy_s2;
			for (int i = 0; i < 4; i++)
				ar_s3[i] <= AW'(pl_s2[i]) - AW'(pr_s2[i]);
		end
	end

	// stage 4: owning triangle, side test, flags
	logic                 sp, ok, vop, op_ok, flip;
	logic signed [AW-1:0] own_c, aa_c;

	always_comb begin
		sp    = ar_s3[2] > 0;
		vop   = op_s3 <= OP_VAL5;
		op_ok = op_s3 <= OP_GRAD5;
		flip  = (op_s3 == OP_GRAD5) && !sp;
		case (op_s3) inside
			OP_VAL5, OP_GRAD5: begin
				own_c = sp ? ar_s3[0] : ar_s3[1];
				aa_c  = sp ? ar_s3[2] : -ar_s3[2];
				ok    = 1'b1;
			end
			OP_VAL1, OP_VAL2, OP_GRAD1, OP_GRAD2: begin
				own_c = ar_s3[0];
				aa_c  = ar_s3[3];
				ok    = sp;
			end
			default: begin
				own_c = ar_s3[1];
				aa_c  = ar_s3[3];
				ok    = ar_s3[2] < 0;
			end
		endcase
	end

	logic                 vld_s4, vop_s4, kill_s4, zero_s4;
	logic signed [AW-1:0] own_s4, aa_s4;
	logic signed [DW-1:0] gx_s4, gy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			own_s4  <= own_c;
			aa_s4   <= aa_c;
			gx_s4   <= flip ? -gx_s3 : gx_s3;
			gy_s4   <= flip ? -gy_s3 : gy_s3;
			vop_s4  <= vop;
			kill_s4 <= !op_ok || (own_c == '0) || !ok;
			zero_s4 <= op_ok && (own_c == '0);
		end
	end

	// stage 5: signed dividends, value (own-2a)*2^FB, gradient -d*2^(2FB+1)
	logic signed [NSW-1:0] nv, ng1, ng2;

	always_comb begin
		nv  = (NSW'(own_s4) - (NSW'(aa_s4) <<< 1)) <<< FB;
		ng1 = -(NSW'(gx_s4) <<< (2 * FB + 1));
		ng2 = -(NSW'(gy_s4) <<< (2 * FB + 1));
	end

	logic vld_s5;
	geo_t geo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s5.n1   <= vop_s4 ? nv : ng1;
			geo_s5.n2   <= vop_s4 ? '0 : ng2;
			geo_s5.own  <= own_s4;
			geo_s5.kill <= kill_s4;
			geo_s5.zero <= zero_s4;
		end
	end

	assign out_valid = vld_s5;
	assign geo       = geo_s5;

endmodule

>>> design/ttbe_div.sv
// Two-lane pipelined rounding divider with saturation, one quotient bit a stage
module ttbe_div import ttbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  geo_t geo,
	output logic out_valid,
	output res_t res
);

	// entry: magnitudes, round-half-away folded into num = 2|n|+|d|, den = 2|d|
	logic [NSW-1:0] nm [2];
	logic [AW-1:0]  om;

	always_comb begin
		nm[0] = geo.n1[NSW-1] ? NSW'(-geo.n1) : NSW'(geo.n1);
		nm[1] = geo.n2[NSW-1] ? NSW'(-geo.n2) : NSW'(geo.n2);
		om    = geo.own[AW-1] ? AW'(-geo.own) : AW'(geo.own);
	end

	logic          vld_s1, kill_s1, zero_s1;
	logic [XW-1:0] num_s1 [2];
	logic [XW-1:0] den_s1;
	logic          neg_s1 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1[0] <= (XW'(nm[0]) << 1) + XW'(om);
			num_s1[1] <= (XW'(nm[1]) << 1) + XW'(om);
			den_s1    <= XW'(om) << 1;
			neg_s1[0] <= geo.n1[NSW-1] ^ geo.own[AW-1];
			neg_s1[1] <= geo.n2[NSW-1] ^ geo.own[AW-1];
			kill_s1   <= geo.kill;
			zero_s1   <= geo.zero;
		end
	end

	// stage index k holds the partial remainder after k quotient bits
	logic          vld_s  [CW];
	logic          kill_s [CW];
	logic          zero_s [CW];
	logic [XW-1:0] den_s  [CW];
	logic [XW-1:0] rem_s  [CW][2];
	logic [CW-2:0] quo_s  [CW][2];
	logic          neg_s  [CW][2];
	logic          sat_s  [CW][2];

	// saturation stage: quotient of 2^(CW-1) or more clips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (adv) vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s[0]  <= den_s1;
			kill_s[0] <= kill_s1;
			zero_s[0] <= zero_s1;
			for (int j = 0; j < 2; j++) begin
				rem_s[0][j] <= num_s1[j];
				quo_s[0][j] <= '0;
				neg_s[0][j] <= neg_s1[j];
				sat_s[0][j] <= num_s1[j] >= (den_s1 << (CW - 1));
			end
		end
	end

	for (genvar k = 0; k < CW - 1; k++) begin : g_bit
		localparam int BI = CW - 2 - k;
		logic [XW-1:0] sub  [2];
		logic          take [2];

		always_comb begin
			for (int j = 0; j < 2; j++) begin
				take[j] = rem_s[k][j] >= (den_s[k] << BI);
				sub[j]  = rem_s[k][j] - (den_s[k] << BI);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (adv) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[k+1]  <= den_s[k];
				kill_s[k+1] <= kill_s[k];
				zero_s[k+1] <= zero_s[k];
				for (int j = 0; j < 2; j++) begin
					rem_s[k+1][j] <= take[j] ? sub[j] : rem_s[k][j];
					quo_s[k+1][j] <= quo_s[k][j] | ((CW-1)'(take[j]) << BI);
					neg_s[k+1][j] <= neg_s[k][j];
					sat_s[k+1][j] <= sat_s[k][j];
				end
			end
		end
	end

	// sign, clip, and forced zero
	logic [CW-1:0] q   [2];
	logic [CW-1:0] fin [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			q[j] = {1'b0, quo_s[CW-1][j]};
			if (kill_s[CW-1])
				fin[j] = '0;
			else if (sat_s[CW-1][j])
				fin[j] = neg_s[CW-1][j] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			else
				fin[j] = neg_s[CW-1][j] ? -q[j] : q[j];
		end
	end

	assign out_valid        = vld_s[CW-1];
	assign res.first_value  = fin[0];
	assign res.second_value = fin[1];
	assign res.zero_area    = zero_s[CW-1];

endmodule

>>> design/twin_triangle_basis_eval.sv
// Top level of the twin-triangle basis value and gradient evaluator
//
//  channel | valid      | stall      | payload       | carries
//  --------+------------+------------+---------------+--------------------------
//  query   | item_valid | item_stall | item (item_t) | op, point, four vertices
//  result  | res_valid  | res_stall  | res (res_t)   | two values, zero_area flag
//
// One query enters per cycle while item_stall is low. The path runs through five
// geometry stages, one divider entry stage, one clip check, CW-1 quotient-bit
// stages of the restoring divider, and the output register.
// arst_n clears every stage valid bit and the output and skid valid flags.
// A stalled result sits in the output register; one more finished transaction
// goes into the skid register, and only then does item_stall rise and freeze
// the whole pipeline.
module twin_triangle_basis_eval import ttbe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	logic adv;        // pipeline moves on
	logic g_valid;
	geo_t geo;
	logic d_valid;
	res_t d_res;

	ttbe_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (item_valid),
		.item      (item),
		.out_valid (g_valid),
		.geo       (geo)
	);

	ttbe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (g_valid),
		.geo       (geo),
		.out_valid (d_valid),
		.res       (d_res)
	);

	// output register plus a one-deep skid
	logic res_valid_q, skid_v_q, out_rdy;
	res_t res_q, skid_q;

	assign out_rdy    = !res_valid_q || !res_stall;
	assign adv        = !skid_v_q;
	assign item_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (out_rdy) begin
			if (skid_v_q) begin
				res_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				res_valid_q <= d_valid;
			end
		end else if (adv && d_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			res_q <= skid_v_q ? skid_q : d_res;
		end else if (adv && d_valid) begin
			skid_q <= d_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> design/ttbe_chk.sv
// Port-level checker for the basis evaluator, bound to the top level
`include "twin_triangle_basis_eval_defines.svh"

module ttbe_chk import ttbe_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  item_valid,
	input logic  item_stall,
	input item_t item,
	input logic  res_valid,
	input logic  res_stall,
	input res_t  res
);

	`TTBE_CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result transaction changed while stalled")
	`TTBE_CHK_NOW(a_zero_forces, res_valid && res.zero_area, res.first_value == '0 && res.second_value == '0, "zero area with nonzero result")
	`TTBE_CHK_NOW(a_stall_needs_res, item_stall, res_valid, "query stalled with no result waiting")
	`TTBE_CHK_NOW(a_stall_cause, item_stall, $past(res_valid && res_stall), "query stall without a stalled result before it")

endmodule

bind twin_triangle_basis_eval ttbe_chk u_chk (.*);
